// File: design/wavelength_to_rgb_color_defines.svh
// Assertion macros shared by the design files.
`ifndef WAVELENGTH_TO_RGB_COLOR_DEFINES_SVH
`define WAVELENGTH_TO_RGB_COLOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WTRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wtrc check failed");

// The consequent must hold in the cycle after the antecedent.
`define WTRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wtrc check failed");

`endif

// File: design/wtrc_pkg.sv
package wtrc_pkg;

	localparam logic [13:0] WL_MIN_Q4  = 14'd6080;
	localparam logic [13:0] WL_MAX_Q4  = 14'd12000;
	localparam logic [12:0] ONE_Q12    = 13'd4096;
	localparam logic [12:0] D_MAX      = 13'd5920;
	localparam logic [14:0] HS_MAX     = 15'd20480;

	// floor(d * 128 / 37) equals (d * HUE_RECIP) >> HUE_SHIFT for every d below 2^13.
	localparam logic [20:0] HUE_RECIP  = 21'd1813754;
	localparam int          HUE_SHIFT  = 19;
	localparam int          PROD_W     = 34;

	localparam logic [2:0] SECTOR_0 = 3'd0;
	localparam logic [2:0] SECTOR_1 = 3'd1;
	localparam logic [2:0] SECTOR_2 = 3'd2;
	localparam logic [2:0] SECTOR_3 = 3'd3;
	localparam logic [2:0] SECTOR_4 = 3'd4;
	localparam logic [2:0] SECTOR_5 = 3'd5;

	typedef struct packed {
		logic [14:0] hs;
		logic [12:0] chroma;
		logic [12:0] v;
	} wtrc_mid_t;

endpackage

// File: design/wtrc_light_if.sv
interface wtrc_light_if;
	logic        valid;
	logic        ready;
	logic [13:0] wavelength_q4;
	logic [12:0] monochromaticity;
	logic [12:0] amplitude;

	modport source (output valid, output wavelength_q4, output monochromaticity,
		output amplitude, input ready);
	modport sink (input valid, input wavelength_q4, input monochromaticity,
		input amplitude, output ready);
endinterface

// File: design/wtrc_color_if.sv
interface wtrc_color_if;
	logic        valid;
	logic        ready;
	logic [12:0] red;
	logic [12:0] green;
	logic [12:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// File: design/wtrc_front.sv
`include "wavelength_to_rgb_color_defines.svh"

module wtrc_front (
	input  logic               clk,
	input  logic               arst_n,
	wtrc_light_if.sink         light,
	output logic               mid_valid,
	input  logic               mid_ready,
	output wtrc_pkg::wtrc_mid_t mid
);

	logic                        valid_s1;
	logic [12:0]                 d_s1;
	logic [12:0]                 s_s1;
	logic [12:0]                 v_s1;
	logic                        valid_s2;
	logic [wtrc_pkg::PROD_W-1:0] prod_s2;
	logic [25:0]                 vs_s2;
	logic [12:0]                 v_s2;

	logic [13:0] wq_clamped;
	logic [12:0] s_clamped;
	logic [12:0] v_clamped;
	logic [13:0] d_wide;
	logic        en_s1;
	logic        en_s2;

	assign en_s2       = !valid_s2 || mid_ready;
	assign en_s1       = !valid_s1 || en_s2;
	assign light.ready = en_s1;

	always_comb begin
		if (light.wavelength_q4 < wtrc_pkg::WL_MIN_Q4) begin
			wq_clamped = wtrc_pkg::WL_MIN_Q4;
		end else if (light.wavelength_q4 > wtrc_pkg::WL_MAX_Q4) begin
			wq_clamped = wtrc_pkg::WL_MAX_Q4;
		end else begin
			wq_clamped = light.wavelength_q4;
		end
		s_clamped = (light.monochromaticity > wtrc_pkg::ONE_Q12) ?
			wtrc_pkg::ONE_Q12 : light.monochromaticity;
		v_clamped = (light.amplitude > wtrc_pkg::ONE_Q12) ?
			wtrc_pkg::ONE_Q12 : light.amplitude;
		d_wide = wtrc_pkg::WL_MAX_Q4 - wq_clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= light.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d_s1 <= d_wide[12:0];
			s_s1 <= s_clamped;
			v_s1 <= v_clamped;
		end
		if (en_s2) begin
			prod_s2 <= wtrc_pkg::PROD_W'(d_s1) * wtrc_pkg::PROD_W'(wtrc_pkg::HUE_RECIP);
			vs_s2   <= 26'(v_s1) * 26'(s_s1);
			v_s2    <= v_s1;
		end
	end

	assign mid_valid  = valid_s2;
	assign mid.hs     = prod_s2[wtrc_pkg::PROD_W-1:wtrc_pkg::HUE_SHIFT];
	assign mid.chroma = vs_s2[24:12];
	assign mid.v      = v_s2;

	`WTRC_ASSERT_NOW(a_d_range, clk, arst_n, valid_s1, d_s1 <= wtrc_pkg::D_MAX)
	`WTRC_ASSERT_NOW(a_hs_range, clk, arst_n, valid_s2,
		(mid.hs <= wtrc_pkg::HS_MAX) && (mid.chroma <= mid.v))

endmodule

// File: design/wtrc_back.sv
`include "wavelength_to_rgb_color_defines.svh"

module wtrc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mid_valid,
	output logic               mid_ready,
	input  wtrc_pkg::wtrc_mid_t mid,
	wtrc_color_if.source       color
);

	logic        valid_s3;
	logic [2:0]  sector_s3;
	logic [12:0] c_s3;
	logic [12:0] x_s3;
	logic [12:0] m_s3;
	logic        valid_s4;
	logic [12:0] red_s4;
	logic [12:0] green_s4;
	logic [12:0] blue_s4;

	logic [12:0] f2;
	logic [12:0] t;
	logic [12:0] one_minus_t;
	logic [25:0] x_prod;
	logic [12:0] cm;
	logic [12:0] xm;
	logic [12:0] r_n;
	logic [12:0] g_n;
	logic [12:0] b_n;
	logic        en_s3;
	logic        en_s4;

	assign en_s4     = !valid_s4 || color.ready;
	assign en_s3     = !valid_s3 || en_s4;
	assign mid_ready = en_s3;

	always_comb begin
		f2          = mid.hs[12:0];
		t           = (f2 >= wtrc_pkg::ONE_Q12) ? (f2 - wtrc_pkg::ONE_Q12) :
			(wtrc_pkg::ONE_Q12 - f2);
		one_minus_t = wtrc_pkg::ONE_Q12 - t;
		x_prod      = 26'(mid.chroma) * 26'(one_minus_t);
	end

	always_comb begin
		cm = c_s3 + m_s3;
		xm = x_s3 + m_s3;
		case (sector_s3)
			wtrc_pkg::SECTOR_0: begin
				r_n = cm;   g_n = xm;   b_n = m_s3;
			end
			wtrc_pkg::SECTOR_1: begin
				r_n = xm;   g_n = cm;   b_n = m_s3;
			end
			wtrc_pkg::SECTOR_2: begin
				r_n = m_s3; g_n = cm;   b_n = xm;
			end
			wtrc_pkg::SECTOR_3: begin
				r_n = m_s3; g_n = xm;   b_n = cm;
			end
			wtrc_pkg::SECTOR_4: begin
				r_n = xm;   g_n = m_s3; b_n = cm;
			end
			wtrc_pkg::SECTOR_5: begin
				r_n = cm;   g_n = m_s3; b_n = xm;
			end
			default: begin
				r_n = m_s3; g_n = m_s3; b_n = m_s3;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= mid_valid;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sector_s3 <= mid.hs[14:12];
			c_s3      <= mid.chroma;
			x_s3      <= x_prod[24:12];
			m_s3      <= mid.v - mid.chroma;
		end
		if (en_s4) begin
			red_s4   <= r_n;
			green_s4 <= g_n;
			blue_s4  <= b_n;
		end
	end

	assign color.valid = valid_s4;
	assign color.red   = red_s4;
	assign color.green = green_s4;
	assign color.blue  = blue_s4;

	`WTRC_ASSERT_NOW(a_x_le_c, clk, arst_n, valid_s3,
		(x_s3 <= c_s3) && (sector_s3 <= wtrc_pkg::SECTOR_5))
	`WTRC_ASSERT_NOW(a_out_range, clk, arst_n, valid_s4,
		(red_s4 <= wtrc_pkg::ONE_Q12) && (green_s4 <= wtrc_pkg::ONE_Q12) &&
		(blue_s4 <= wtrc_pkg::ONE_Q12))
	`WTRC_ASSERT_NEXT(a_s3_hold, clk, arst_n, valid_s3 && !en_s4,
		valid_s3 && $stable(x_s3) && $stable(m_s3))

endmodule

// File: design/wavelength_to_rgb_color.sv
// Channel   Role    Fields
// light     sink    wavelength_q4[13:0], monochromaticity[12:0], amplitude[12:0]
// color     source  red[12:0], green[12:0], blue[12:0]
//
// Each item passes four register stages, and one item can enter every cycle while the
// color side is not stalling; the four stages are clamp, two multiplies, the tent
// multiply for the secondary component, and the sector mix into the output register.
// Reset clears only the stage valid bits.
// A stall on the color side holds each full stage whose next stage is held; an empty
// stage still takes the item behind it.

module wavelength_to_rgb_color (
	input  logic         clk,
	input  logic         arst_n,
	wtrc_light_if.sink   light,
	wtrc_color_if.source color
);

	logic                mid_valid;
	logic                mid_ready;
	wtrc_pkg::wtrc_mid_t mid;

	wtrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.light     (light),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid)
	);

	wtrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (mid_valid),
		.mid_ready (mid_ready),
		.mid       (mid),
		.color     (color)
	);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

typedef struct packed {
	logic [13:0] wavelength_q4;
	logic [12:0] monochromaticity;
	logic [12:0] amplitude;
} light_item_t;

typedef struct packed {
	logic [12:0] red;
	logic [12:0] green;
	logic [12:0] blue;
} color_item_t;

class color_scoreboard;
	localparam int unsigned SECTOR_SPAN_Q4 = 1184;

	color_item_t expected_colors[$];
	int          errors;

	function new();
		errors = 0;
	endfunction

	function color_item_t predict_color(light_item_t it);
		logic [13:0] wq;
		logic [12:0] sat, val, d, chroma, f2, t, x, m, cm, xm;
		logic [14:0] hs;
		logic [2:0]  sector;
		color_item_t c;
		wq = it.wavelength_q4;
		if (wq < wtrc_pkg::WL_MIN_Q4) begin
			wq = wtrc_pkg::WL_MIN_Q4;
		end else if (wq > wtrc_pkg::WL_MAX_Q4) begin
			wq = wtrc_pkg::WL_MAX_Q4;
		end
		sat = (it.monochromaticity > wtrc_pkg::ONE_Q12) ? wtrc_pkg::ONE_Q12 :
			it.monochromaticity;
		val = (it.amplitude > wtrc_pkg::ONE_Q12) ? wtrc_pkg::ONE_Q12 : it.amplitude;
		d = 13'(wtrc_pkg::WL_MAX_Q4 - wq);
		hs = 15'((32'(d) * 32'(wtrc_pkg::ONE_Q12)) / SECTOR_SPAN_Q4);
		chroma = 13'((26'(val) * 26'(sat)) >> 12);
		f2 = hs[12:0];
		t = (f2 >= wtrc_pkg::ONE_Q12) ? f2 - wtrc_pkg::ONE_Q12 : wtrc_pkg::ONE_Q12 - f2;
		x = 13'((26'(chroma) * 26'(wtrc_pkg::ONE_Q12 - t)) >> 12);
		m = val - chroma;
		cm = chroma + m;
		xm = x + m;
		sector = hs[14:12];
		case (sector)
			wtrc_pkg::SECTOR_0: c = '{red: cm, green: xm, blue: m};
			wtrc_pkg::SECTOR_1: c = '{red: xm, green: cm, blue: m};
			wtrc_pkg::SECTOR_2: c = '{red: m, green: cm, blue: xm};
			wtrc_pkg::SECTOR_3: c = '{red: m, green: xm, blue: cm};
			wtrc_pkg::SECTOR_4: c = '{red: xm, green: m, blue: cm};
			wtrc_pkg::SECTOR_5: c = '{red: cm, green: m, blue: xm};
			default:            c = '{red: m, green: m, blue: m};
		endcase
		return c;
	endfunction

	function void note_light(light_item_t it);
		expected_colors = {expected_colors, predict_color(it)};
	endfunction

	function void compare_field(string name, logic [12:0] want, logic [12:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_color(color_item_t got);
		color_item_t want;
		if (expected_colors.size() == 0) begin
			$display("%0t: unexpected color item, expected none, actual r=%0d g=%0d b=%0d",
				$time, got.red, got.green, got.blue);
			errors++;
			return;
		end
		want = expected_colors.pop_front();
		compare_field("red", want.red, got.red);
		compare_field("green", want.green, got.green);
		compare_field("blue", want.blue, got.blue);
	endfunction
endclass

module tb_top;
	logic clk;
	logic arst_n;

	wtrc_light_if light_ch();
	wtrc_color_if color_ch();

	wavelength_to_rgb_color i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.light  (light_ch),
		.color  (color_ch)
	);

	color_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int hold_cycles;
	int idle_tab[4]  = '{0, 64, 0, 23};
	int stall_tab[4] = '{0, 0, 64, 23};

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#200000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (light_ch.valid && light_ch.ready) begin
				sb.note_light('{light_ch.wavelength_q4, light_ch.monochromaticity,
					light_ch.amplitude});
			end
			if (color_ch.valid && color_ch.ready) begin
				sb.check_color('{color_ch.red, color_ch.green, color_ch.blue});
			end
		end
	end

	// The long hold-off is counted here, so the sender keeps offering items meanwhile.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			color_ch.ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			color_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_light(input light_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			light_ch.valid <= 1'b0;
		end
		@(negedge clk);
		light_ch.valid            <= 1'b1;
		light_ch.wavelength_q4    <= it.wavelength_q4;
		light_ch.monochromaticity <= it.monochromaticity;
		light_ch.amplitude        <= it.amplitude;
		do begin
			@(posedge clk);
		end while (!light_ch.ready);
	endtask

	task automatic wait_for_colors();
		@(negedge clk);
		light_ch.valid <= 1'b0;
		while (sb.expected_colors.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic light_item_t random_light();
		light_item_t it;
		it.wavelength_q4 = ($urandom_range(99) < 70) ? 14'($urandom_range(6080, 12000))
			: 14'($urandom_range(16383));
		it.monochromaticity = ($urandom_range(99) < 60) ? 13'($urandom_range(4096))
			: 13'($urandom_range(8191));
		it.amplitude = ($urandom_range(99) < 60) ? 13'($urandom_range(4096))
			: 13'($urandom_range(8191));
		return it;
	endfunction

	light_item_t directed[$] = '{
		'{14'd0, 13'd4096, 13'd4096},
		'{14'd6079, 13'd4096, 13'd4096},
		'{14'd6080, 13'd4096, 13'd4096},
		'{14'd12000, 13'd4096, 13'd4096},
		'{14'd12001, 13'd4096, 13'd4096},
		'{14'd16383, 13'd8191, 13'd8191},
		'{14'd11408, 13'd4096, 13'd4096},
		'{14'd10816, 13'd4096, 13'd4096},
		'{14'd9632, 13'd4096, 13'd4096},
		'{14'd9040, 13'd4096, 13'd4096},
		'{14'd8448, 13'd4096, 13'd4096},
		'{14'd7264, 13'd4096, 13'd4096},
		'{14'd6672, 13'd3000, 13'd4000},
		'{14'd10000, 13'd0, 13'd4096},
		'{14'd10000, 13'd4096, 13'd0},
		'{14'd8000, 13'd8191, 13'd1},
		'{14'd8000, 13'd1, 13'd8191},
		'{14'd7000, 13'd4097, 13'd4097},
		'{14'd10000, 13'd0, 13'd0},
		'{14'd7000, 13'd2048, 13'd3000},
		'{14'd16383, 13'd0, 13'd8191},
		'{14'd11999, 13'd4095, 13'd4095}
	};

	initial begin
		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		light_ch.valid = 1'b0;
		light_ch.wavelength_q4 = '0;
		light_ch.monochromaticity = '0;
		light_ch.amplitude = '0;
		color_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			send_light(directed[i]);
		end
		wait_for_colors();

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = idle_tab[phase];
			stall_pct = stall_tab[phase];
			for (int n = 0; n < 345; n++) begin
				if (phase == 0 && n == 150) begin
					hold_cycles = 300;
				end
				send_light(random_light());
			end
			wait_for_colors();
		end

		stall_pct = 0;
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.expected_colors.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+design
design/wtrc_pkg.sv
design/wtrc_light_if.sv
design/wtrc_color_if.sv
design/wtrc_front.sv
design/wtrc_back.sv
design/wavelength_to_rgb_color.sv
tb/tb_top.sv
